// ----- hdl/sgli_pkg.sv -----
package sgli_pkg;

    localparam int EW  = 64;
    localparam int VW  = 48;
    localparam int XW  = 12;
    localparam int CFW = 13;
    localparam int DVW = VW + 1;
    localparam int PW  = EW + DVW;
    localparam int QW  = 51;
    localparam int SW  = 53;
    localparam int MCW = 16;

    typedef logic [4:0] t_state;

    localparam t_state ST_IDLE = 5'd0;
    localparam t_state ST_RD0  = 5'd1;
    localparam t_state ST_CMP0 = 5'd2;
    localparam t_state ST_RDN  = 5'd3;
    localparam t_state ST_CMPN = 5'd4;
    localparam t_state ST_SRCH = 5'd5;
    localparam t_state ST_RDM  = 5'd6;
    localparam t_state ST_CMPM = 5'd7;
    localparam t_state ST_RDI0 = 5'd8;
    localparam t_state ST_CAP0 = 5'd9;
    localparam t_state ST_RDI1 = 5'd10;
    localparam t_state ST_CAP1 = 5'd11;
    localparam t_state ST_MATH = 5'd12;
    localparam t_state ST_MUL  = 5'd13;
    localparam t_state ST_DCHK = 5'd14;
    localparam t_state ST_DIV  = 5'd15;
    localparam t_state ST_RND  = 5'd16;
    localparam t_state ST_FIN  = 5'd17;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

endpackage

// ----- hdl/sgli_ram.sv -----
module sgli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/sorted_grid_linear_interpolator.sv -----
// Piecewise linear table interpolator over an ascending energy grid.
// Input channel (i_in_valid / o_in_stall) carries one item per transfer.
// A load (mode 0) writes energy and value at entry_index and
// gives no result; indexes at or beyond TABLE_DEPTH are dropped.
// A query (mode 1) gives one result on the output channel (o_out_valid /
// i_out_stall): the interpolated or extrapolated value, saturated to 48 bits,
// the left interval index and a saturation flag.
// A query runs a binary search unless the energy lies below or above the
// grid, and reads once more past a repeated point. Each search step sets the
// address, reads (registered) and compares; the product takes four 64x16
// steps and the quotient is formed one bit per cycle, 51 bits in all; a
// clipped quotient or a zero-width interval ends sooner.
// One item is in work at a time; o_in_stall is high while a query runs.
// The finished result sits in an output register, so a new item is taken
// while the receiver stalls; a second result waits until that register frees.
// The register points_in_use is written through i_cfg_wr_en / i_cfg_wr_data
// while idle; the user must keep to this, as the block does not enforce it.
// Values outside 2..TABLE_DEPTH act as the nearest limit. Reset sets
// points_in_use to 2 and clears the state and o_out_valid; the table
// memories are not cleared and must be loaded before a query.
module sorted_grid_linear_interpolator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sgli_pkg::CFW-1:0]           i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_mode,
    input  logic [sgli_pkg::XW-1:0]            i_entry_index,
    input  logic [sgli_pkg::EW-1:0]            i_point_energy,
    input  logic signed [sgli_pkg::VW-1:0]     i_table_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [sgli_pkg::VW-1:0]     o_interpolated_value,
    output logic [sgli_pkg::XW-1:0]            o_interval_index,
    output logic                               o_saturated
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = sgli_pkg::EW;
    localparam int VW = sgli_pkg::VW;
    localparam int PW = sgli_pkg::PW;
    localparam int QW = sgli_pkg::QW;
    localparam int SW = sgli_pkg::SW;
    localparam int MCW = sgli_pkg::MCW;
    localparam int DVW = sgli_pkg::DVW;

    sgli_pkg::t_state r_state, n_state;
    logic [sgli_pkg::CFW-1:0] r_points;
    logic [EW-1:0]       r_e, n_e, r_e0, n_e0, r_e1, n_e1, r_w, n_w;
    logic [EW-1:0]       r_dmag, n_dmag, r_rem, n_rem;
    logic [VW-1:0]       r_v0, n_v0, r_v1, n_v1;
    logic [DVW-1:0]      r_dvmag, n_dvmag;
    logic                r_neg, n_neg, r_adv, n_adv;
    logic [AW-1:0]       r_addr, n_addr, r_i, n_i, r_lo, n_lo, r_hi, n_hi;
    logic [PW-1:0]       r_acc, n_acc;
    logic [QW-1:0]       r_num, n_num;
    logic [QW:0]         r_q, n_q;
    logic [5:0]          r_cnt, n_cnt;
    logic [1:0]          r_k, n_k;
    logic                r_ovalid, n_ovalid, r_osat, n_osat;
    logic [VW-1:0]       r_oval, n_oval;
    logic [AW-1:0]       r_oidx, n_oidx;

    logic                in_xfer, wr_ok, wr_en;
    logic [31:0]         n_use;
    logic [AW-1:0]       nm1, nm2, wr_addr, mid;
    logic [AW:0]         span, pair;
    logic [EW-1:0]       rd_e;
    logic [VW-1:0]       rd_v;
    logic [63:0]         dv_ext;
    logic [MCW-1:0]      chunk;
    logic [EW+MCW-1:0]   prod;
    logic [EW:0]         trial;
    logic [DVW-1:0]      dv;
    logic [QW:0]         q_rnd;
    logic signed [SW-1:0] sum;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign wr_ok   = 32'(i_entry_index) < 32'(TABLE_DEPTH);
    assign wr_en   = in_xfer && (i_mode == sgli_pkg::MODE_LOAD) && wr_ok;
    assign wr_addr = AW'(i_entry_index);

    sgli_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_energy_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_point_energy),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_e)
    );

    sgli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_table_value),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_v)
    );

    always_comb begin
        if (r_points < 13'd2) begin
            n_use = 32'd2;
        end else if (32'(r_points) > 32'(TABLE_DEPTH)) begin
            n_use = 32'(TABLE_DEPTH);
        end else begin
            n_use = 32'(r_points);
        end
    end

    assign nm1    = AW'(n_use - 32'd1);
    assign nm2    = AW'(n_use - 32'd2);
    assign span   = {1'b0, r_hi} - {1'b0, r_lo};
    assign pair   = {1'b0, r_hi} + {1'b0, r_lo};
    assign mid    = pair[AW:1];
    assign dv     = {r_v1[VW-1], r_v1} - {r_v0[VW-1], r_v0};
    assign dv_ext = 64'(r_dvmag);
    assign chunk  = dv_ext[r_k*MCW +: MCW];
    assign prod   = r_dmag * chunk;
    assign trial  = {r_rem, r_num[QW-1]};
    assign q_rnd  = r_q + (QW+1)'(r_rem >= (r_w - r_rem));
    assign sum    = r_neg ? (SW'(signed'(r_v0)) - signed'(SW'(r_q)))
                          : (SW'(signed'(r_v0)) + signed'(SW'(r_q)));

    always_comb begin
        n_state  = r_state;
        n_e      = r_e;
        n_e0     = r_e0;
        n_e1     = r_e1;
        n_w      = r_w;
        n_dmag   = r_dmag;
        n_rem    = r_rem;
        n_v0     = r_v0;
        n_v1     = r_v1;
        n_dvmag  = r_dvmag;
        n_neg    = r_neg;
        n_adv    = r_adv;
        n_addr   = r_addr;
        n_i      = r_i;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_acc    = r_acc;
        n_num    = r_num;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_ovalid = r_ovalid && i_out_stall;
        n_osat   = r_osat;
        n_oval   = r_oval;
        n_oidx   = r_oidx;
        case (r_state)
            sgli_pkg::ST_IDLE: begin
                if (in_xfer && i_mode == sgli_pkg::MODE_QUERY) begin
                    n_e     = i_point_energy;
                    n_addr  = '0;
                    n_adv   = 1'b0;
                    n_state = sgli_pkg::ST_RD0;
                end
            end
            sgli_pkg::ST_RD0: n_state = sgli_pkg::ST_CMP0;
            sgli_pkg::ST_CMP0: begin
                if (r_e < rd_e) begin
                    n_i     = '0;
                    n_addr  = '0;
                    n_state = sgli_pkg::ST_RDI0;
                end else begin
                    n_addr  = nm1;
                    n_state = sgli_pkg::ST_RDN;
                end
            end
            sgli_pkg::ST_RDN: n_state = sgli_pkg::ST_CMPN;
            sgli_pkg::ST_CMPN: begin
                if (r_e > rd_e) begin
                    n_i     = nm2;
                    n_addr  = nm2;
                    n_state = sgli_pkg::ST_RDI0;
                end else begin
                    n_lo    = '0;
                    n_hi    = nm1;
                    n_state = sgli_pkg::ST_SRCH;
                end
            end
            sgli_pkg::ST_SRCH: begin
                if (span > (AW+1)'(1)) begin
                    n_addr  = mid;
                    n_state = sgli_pkg::ST_RDM;
                end else begin
                    n_i     = r_lo;
                    n_addr  = r_lo;
                    n_state = sgli_pkg::ST_RDI0;
                end
            end
            sgli_pkg::ST_RDM: n_state = sgli_pkg::ST_CMPM;
            sgli_pkg::ST_CMPM: begin
                if (rd_e <= r_e) begin
                    n_lo = r_addr;
                end else begin
                    n_hi = r_addr;
                end
                n_state = sgli_pkg::ST_SRCH;
            end
            sgli_pkg::ST_RDI0: n_state = sgli_pkg::ST_CAP0;
            sgli_pkg::ST_CAP0: begin
                n_e0    = rd_e;
                n_v0    = rd_v;
                n_addr  = r_i + AW'(1);
                n_state = sgli_pkg::ST_RDI1;
            end
            sgli_pkg::ST_RDI1: n_state = sgli_pkg::ST_CAP1;
            sgli_pkg::ST_CAP1: begin
                n_e1 = rd_e;
                n_v1 = rd_v;
                if (!r_adv && r_i < nm2 && rd_e == r_e0) begin
                    n_adv   = 1'b1;
                    n_e0    = rd_e;
                    n_v0    = rd_v;
                    n_i     = r_i + AW'(1);
                    n_addr  = r_i + AW'(2);
                    n_state = sgli_pkg::ST_RDI1;
                end else begin
                    n_state = sgli_pkg::ST_MATH;
                end
            end
            sgli_pkg::ST_MATH: begin
                n_w     = r_e1 - r_e0;
                n_dmag  = (r_e < r_e0) ? (r_e0 - r_e) : (r_e - r_e0);
                n_dvmag = dv[DVW-1] ? (-dv) : dv;
                n_neg   = (r_e < r_e0) != dv[DVW-1];
                n_acc   = '0;
                n_k     = '0;
                n_q     = '0;
                if (r_e1 <= r_e0) begin
                    n_neg   = 1'b0;
                    n_state = sgli_pkg::ST_FIN;
                end else begin
                    n_state = sgli_pkg::ST_MUL;
                end
            end
            sgli_pkg::ST_MUL: begin
                n_acc = r_acc + (PW'(prod) << {r_k, 4'b0000});
                n_k   = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = sgli_pkg::ST_DCHK;
                end
            end
            sgli_pkg::ST_DCHK: begin
                if (EW'(r_acc[PW-1:QW]) >= r_w) begin
                    n_q     = (QW+1)'(1) << (QW-1);
                    n_state = sgli_pkg::ST_FIN;
                end else begin
                    n_rem   = EW'(r_acc[PW-1:QW]);
                    n_num   = r_acc[QW-1:0];
                    n_q     = '0;
                    n_cnt   = 6'(QW - 1);
                    n_state = sgli_pkg::ST_DIV;
                end
            end
            sgli_pkg::ST_DIV: begin
                if (trial >= {1'b0, r_w}) begin
                    n_rem = EW'(trial - {1'b0, r_w});
                    n_q   = {r_q[QW-1:0], 1'b1};
                end else begin
                    n_rem = EW'(trial);
                    n_q   = {r_q[QW-1:0], 1'b0};
                end
                n_num = {r_num[QW-2:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = sgli_pkg::ST_RND;
                end
            end
            sgli_pkg::ST_RND: begin
                if (q_rnd > ((QW+1)'(1) << (QW-1))) begin
                    n_q = (QW+1)'(1) << (QW-1);
                end else begin
                    n_q = q_rnd;
                end
                n_state = sgli_pkg::ST_FIN;
            end
            sgli_pkg::ST_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_i;
                    if (sum > SW'(sgli_pkg::VAL_MAX)) begin
                        n_oval = sgli_pkg::VAL_MAX;
                        n_osat = 1'b1;
                    end else if (sum < SW'(sgli_pkg::VAL_MIN)) begin
                        n_oval = sgli_pkg::VAL_MIN;
                        n_osat = 1'b1;
                    end else begin
                        n_oval = VW'(sum);
                        n_osat = 1'b0;
                    end
                    n_state = sgli_pkg::ST_IDLE;
                end
            end
            default: n_state = sgli_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sgli_pkg::ST_IDLE;
            r_points <= 13'd2;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_points <= i_cfg_wr_data;
            end
        end
        r_e     <= n_e;
        r_e0    <= n_e0;
        r_e1    <= n_e1;
        r_w     <= n_w;
        r_dmag  <= n_dmag;
        r_rem   <= n_rem;
        r_v0    <= n_v0;
        r_v1    <= n_v1;
        r_dvmag <= n_dvmag;
        r_neg   <= n_neg;
        r_adv   <= n_adv;
        r_addr  <= n_addr;
        r_i     <= n_i;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_acc   <= n_acc;
        r_num   <= n_num;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        r_osat  <= n_osat;
        r_oval  <= n_oval;
        r_oidx  <= n_oidx;
    end

    assign o_in_stall           = (r_state != sgli_pkg::ST_IDLE);
    assign o_out_valid          = r_ovalid;
    assign o_interpolated_value = r_oval;
    assign o_interval_index     = sgli_pkg::XW'(r_oidx);
    assign o_saturated          = r_osat;

endmodule

// ----- hdl/sgli_chk.sv -----
module sgli_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_mode,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [sgli_pkg::VW-1:0] o_interpolated_value,
    input logic [sgli_pkg::XW-1:0]        o_interval_index,
    input logic                           o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_interpolated_value) && $stable(o_interval_index)
            && $stable(o_saturated))
        else $error("stalled result changed");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode == sgli_pkg::MODE_LOAD
            |=> !$rose(o_out_valid))
        else $error("load produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode == sgli_pkg::MODE_QUERY |=> o_in_stall)
        else $error("query did not hold the input");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_interpolated_value == sgli_pkg::VAL_MAX
            || o_interpolated_value == sgli_pkg::VAL_MIN)
        else $error("saturated flag without clipped value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or busy after reset");

endmodule

bind sorted_grid_linear_interpolator sgli_chk u_sgli_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .i_mode               (i_mode),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_interpolated_value (o_interpolated_value),
    .o_interval_index     (o_interval_index),
    .o_saturated          (o_saturated)
);
